// File: rtl/core/isd_pkg.sv
// isd_pkg: shared constants and types for the in-sphere determinant pipeline
// used by every module under rtl/core; depends on nothing

package isd_pkg;

   // coordinate packing: three slots per point, x lowest
   localparam int COORD_BITS_DEF = 10;
   localparam int SLOT_BITS      = 10;
   localparam int AXES           = 3;
   localparam int POINT_BITS     = AXES * SLOT_BITS;
   localparam int NUM_POINTS     = 4;

   // axis indices within a lifted row
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;

   // result width
   localparam int DET_BITS = 64;

   // side codes
   typedef logic [1:0] side_type;
   localparam side_type SIDE_ZERO = 2'd0;
   localparam side_type SIDE_POS  = 2'd1;
   localparam side_type SIDE_NEG  = 2'd2;

endpackage

// File: rtl/core/isd_lift.sv
// isd_lift: first two pipeline stages, point differences and squared lengths
// depends on isd_pkg

module isd_lift #(
   parameter int COORD_BITS = isd_pkg::COORD_BITS_DEF,
   localparam int DW = COORD_BITS + 1,
   localparam int SW = 2 * COORD_BITS + 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  logic [isd_pkg::POINT_BITS-1:0]  point_a,
   input  logic [isd_pkg::POINT_BITS-1:0]  point_b,
   input  logic [isd_pkg::POINT_BITS-1:0]  point_c,
   input  logic [isd_pkg::POINT_BITS-1:0]  point_d,
   input  logic [isd_pkg::POINT_BITS-1:0]  query_point,
   output logic                            out_valid,
   output logic signed [DW-1:0]            diff_row [isd_pkg::NUM_POINTS][isd_pkg::AXES],
   output logic signed [SW-1:0]            lift_sq [isd_pkg::NUM_POINTS]
);
   import isd_pkg::*;

   logic [POINT_BITS-1:0] pts [NUM_POINTS];
   logic signed [DW-1:0]  diff_in  [NUM_POINTS][AXES];
   logic signed [DW-1:0]  diff_ff  [NUM_POINTS][AXES];
   logic signed [DW-1:0]  diff2_ff [NUM_POINTS][AXES];
   logic signed [SW-1:0]  sq_in [NUM_POINTS];
   logic signed [SW-1:0]  sq_ff [NUM_POINTS];
   logic                  valid1_ff;
   logic                  valid2_ff;

   assign pts[0] = point_a;
   assign pts[1] = point_b;
   assign pts[2] = point_c;
   assign pts[3] = point_d;

   // stage 1: signed coordinate differences against the query point
   always_comb begin
      for (int p = 0; p < NUM_POINTS; p++) begin
         for (int k = 0; k < AXES; k++) begin
            diff_in[p][k] = DW'(signed'(pts[p][k*SLOT_BITS +: COORD_BITS]))
                          - DW'(signed'(query_point[k*SLOT_BITS +: COORD_BITS]));
         end
      end
   end

   // stage 2: squared length of each difference
   always_comb begin
      for (int p = 0; p < NUM_POINTS; p++) begin
         sq_in[p] = '0;
         for (int k = 0; k < AXES; k++) begin
            sq_in[p] = sq_in[p] + SW'(diff_ff[p][k]) * SW'(diff_ff[p][k]);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         diff_ff  <= diff_in;
         diff2_ff <= diff_ff;
         sq_ff    <= sq_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (adv) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   assign out_valid = valid2_ff;
   assign diff_row  = diff2_ff;
   assign lift_sq   = sq_ff;

endmodule

// File: rtl/core/isd_minor.sv
// isd_minor: stages three and four, 2x2 minors of the last two lifted rows
// and then the four 3x3 minors; depends on isd_pkg

module isd_minor #(
   parameter int COORD_BITS = isd_pkg::COORD_BITS_DEF,
   localparam int DW = COORD_BITS + 1,
   localparam int SW = 2 * COORD_BITS + 3,
   localparam int MW = 4 * COORD_BITS + 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic signed [DW-1:0] diff_row [isd_pkg::NUM_POINTS][isd_pkg::AXES],
   input  logic signed [SW-1:0] lift_sq [isd_pkg::NUM_POINTS],
   output logic                 out_valid,
   output logic signed [DW-1:0] row0_diff [isd_pkg::AXES],
   output logic signed [SW-1:0] row0_sq,
   output logic signed [MW-1:0] minor [4]
);
   import isd_pkg::*;

   // 2x2 minor widths: plain coordinate pairs and pairs with the lift column
   localparam int NW = 2 * DW + 1;
   localparam int XW = DW + SW + 1;

   logic signed [DW-1:0] r0_d_ff  [AXES];
   logic signed [SW-1:0] r0_sq_ff;
   logic signed [DW-1:0] r1_d_ff  [AXES];
   logic signed [SW-1:0] r1_sq_ff;
   logic signed [DW-1:0] r0_d2_ff [AXES];
   logic signed [SW-1:0] r0_sq2_ff;

   logic signed [NW-1:0] m_xy_in, m_xz_in, m_yz_in;
   logic signed [NW-1:0] m_xy_ff, m_xz_ff, m_yz_ff;
   logic signed [XW-1:0] m_xs_in, m_ys_in, m_zs_in;
   logic signed [XW-1:0] m_xs_ff, m_ys_ff, m_zs_ff;

   logic signed [MW-1:0] minor_in [4];
   logic signed [MW-1:0] minor_ff [4];

   logic valid3_ff;
   logic valid4_ff;

   // stage 3: 2x2 minors of rows c and d over every column pair
   always_comb begin
      m_xy_in = NW'(diff_row[2][AXIS_X]) * NW'(diff_row[3][AXIS_Y])
              - NW'(diff_row[2][AXIS_Y]) * NW'(diff_row[3][AXIS_X]);
      m_xz_in = NW'(diff_row[2][AXIS_X]) * NW'(diff_row[3][AXIS_Z])
              - NW'(diff_row[2][AXIS_Z]) * NW'(diff_row[3][AXIS_X]);
      m_yz_in = NW'(diff_row[2][AXIS_Y]) * NW'(diff_row[3][AXIS_Z])
              - NW'(diff_row[2][AXIS_Z]) * NW'(diff_row[3][AXIS_Y]);
      m_xs_in = XW'(diff_row[2][AXIS_X]) * XW'(lift_sq[3])
              - XW'(lift_sq[2]) * XW'(diff_row[3][AXIS_X]);
      m_ys_in = XW'(diff_row[2][AXIS_Y]) * XW'(lift_sq[3])
              - XW'(lift_sq[2]) * XW'(diff_row[3][AXIS_Y]);
      m_zs_in = XW'(diff_row[2][AXIS_Z]) * XW'(lift_sq[3])
              - XW'(lift_sq[2]) * XW'(diff_row[3][AXIS_Z]);
   end

   // stage 4: 3x3 minors, expanded along row b
   always_comb begin
      // columns y, z, lift
      minor_in[0] = MW'(r1_d_ff[AXIS_Y]) * MW'(m_zs_ff)
                  - MW'(r1_d_ff[AXIS_Z]) * MW'(m_ys_ff)
                  + MW'(r1_sq_ff) * MW'(m_yz_ff);
      // columns x, z, lift
      minor_in[1] = MW'(r1_d_ff[AXIS_X]) * MW'(m_zs_ff)
                  - MW'(r1_d_ff[AXIS_Z]) * MW'(m_xs_ff)
                  + MW'(r1_sq_ff) * MW'(m_xz_ff);
      // columns x, y, lift
      minor_in[2] = MW'(r1_d_ff[AXIS_X]) * MW'(m_ys_ff)
                  - MW'(r1_d_ff[AXIS_Y]) * MW'(m_xs_ff)
                  + MW'(r1_sq_ff) * MW'(m_xy_ff);
      // columns x, y, z
      minor_in[3] = MW'(r1_d_ff[AXIS_X]) * MW'(m_yz_ff)
                  - MW'(r1_d_ff[AXIS_Y]) * MW'(m_xz_ff)
                  + MW'(r1_d_ff[AXIS_Z]) * MW'(m_xy_ff);
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         r0_d_ff   <= diff_row[0];
         r0_sq_ff  <= lift_sq[0];
         r1_d_ff   <= diff_row[1];
         r1_sq_ff  <= lift_sq[1];
         m_xy_ff   <= m_xy_in;
         m_xz_ff   <= m_xz_in;
         m_yz_ff   <= m_yz_in;
         m_xs_ff   <= m_xs_in;
         m_ys_ff   <= m_ys_in;
         m_zs_ff   <= m_zs_in;
         r0_d2_ff  <= r0_d_ff;
         r0_sq2_ff <= r0_sq_ff;
         minor_ff  <= minor_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else if (adv) begin
         valid3_ff <= in_valid;
         valid4_ff <= valid3_ff;
      end
   end

   assign out_valid = valid4_ff;
   assign row0_diff = r0_d2_ff;
   assign row0_sq   = r0_sq2_ff;
   assign minor     = minor_ff;

endmodule

// File: rtl/core/isd_combine.sv
// isd_combine: stages five and six, cofactor expansion along row a
// with each minor split into two halves for the multipliers; depends on isd_pkg

module isd_combine #(
   parameter int COORD_BITS = isd_pkg::COORD_BITS_DEF,
   localparam int DW = COORD_BITS + 1,
   localparam int SW = 2 * COORD_BITS + 3,
   localparam int MW = 4 * COORD_BITS + 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_valid,
   input  logic signed [DW-1:0]               row0_diff [isd_pkg::AXES],
   input  logic signed [SW-1:0]               row0_sq,
   input  logic signed [MW-1:0]               minor [4],
   output logic                               out_valid,
   output logic signed [isd_pkg::DET_BITS-1:0] det
);
   import isd_pkg::*;

   // low half taken unsigned, high half signed
   localparam int LO  = MW / 2;
   localparam int HI  = MW - LO;
   localparam int PLW = SW + LO + 1;
   localparam int PHW = SW + HI;

   logic signed [SW-1:0]       mult [4];
   logic signed [PLW-1:0]      lo_in [4];
   logic signed [PLW-1:0]      lo_ff [4];
   logic signed [PHW-1:0]      hi_in [4];
   logic signed [PHW-1:0]      hi_ff [4];
   logic signed [DET_BITS-1:0] term [4];
   logic signed [DET_BITS-1:0] det_in;
   logic signed [DET_BITS-1:0] det_ff;
   logic                       valid5_ff;
   logic                       valid6_ff;

   // stage 5: partial products of row a entries with minor halves
   always_comb begin
      mult[0] = SW'(row0_diff[AXIS_X]);
      mult[1] = SW'(row0_diff[AXIS_Y]);
      mult[2] = SW'(row0_diff[AXIS_Z]);
      mult[3] = row0_sq;
      for (int k = 0; k < 4; k++) begin
         lo_in[k] = PLW'(mult[k]) * PLW'(signed'({1'b0, minor[k][LO-1:0]}));
         hi_in[k] = PHW'(mult[k]) * PHW'(signed'(minor[k][MW-1:LO]));
      end
   end

   // stage 6: rejoin halves and sum with alternating signs
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         term[k] = (DET_BITS'(hi_ff[k]) <<< LO) + DET_BITS'(lo_ff[k]);
      end
      det_in = (term[0] + term[2]) - (term[1] + term[3]);
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         det_ff <= det_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid5_ff <= 1'b0;
         valid6_ff <= 1'b0;
      end else if (adv) begin
         valid5_ff <= in_valid;
         valid6_ff <= valid5_ff;
      end
   end

   assign out_valid = valid6_ff;
   assign det       = det_ff;

endmodule

// File: rtl/core/insphere_determinant_unit.sv
// insphere_determinant_unit: top level of the in-sphere determinant pipeline
// depends on isd_pkg, isd_lift, isd_minor and isd_combine
//
// Each item on the req_ channel carries four sphere points and a query point,
// three packed signed Q1.9 coordinates per point (x in the low slot). The
// rsp_ channel returns the exact lifted 4x4 determinant at scale 2^-45 and a
// side code: zero, positive or negative.
// The pipeline has six register stages (differences, squared lengths, 2x2 minors,
// 3x3 minors, partial products, final sum) and takes one item every cycle while
// no finished result is held at the output.
// Reset clears every valid bit, so the pipeline comes up empty; data
// registers are not reset.
// While rsp_valid is high and rsp_stall is high the whole pipeline holds and
// req_stall is raised in the same cycle, so no item is lost or repeated and
// the waiting result stays on the rsp_ ports.
// Items in flight keep moving while the output is empty or being taken.

module insphere_determinant_unit #(
   parameter int COORD_BITS = isd_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [isd_pkg::POINT_BITS-1:0]      req_point_a,
   input  logic [isd_pkg::POINT_BITS-1:0]      req_point_b,
   input  logic [isd_pkg::POINT_BITS-1:0]      req_point_c,
   input  logic [isd_pkg::POINT_BITS-1:0]      req_point_d,
   input  logic [isd_pkg::POINT_BITS-1:0]      req_query_point,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [isd_pkg::DET_BITS-1:0] rsp_determinant,
   output isd_pkg::side_type                   rsp_side
);
   import isd_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int SW = 2 * COORD_BITS + 3;
   localparam int MW = 4 * COORD_BITS + 8;

   logic                 adv;
   logic                 lift_valid;
   logic signed [DW-1:0] diff_row [NUM_POINTS][AXES];
   logic signed [SW-1:0] lift_sq [NUM_POINTS];
   logic                 minor_valid;
   logic signed [DW-1:0] row0_diff [AXES];
   logic signed [SW-1:0] row0_sq;
   logic signed [MW-1:0] minor [4];

   // whole pipeline advances unless a finished item is held at the output
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   isd_lift #(
      .COORD_BITS (COORD_BITS)
   ) u_lift (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .point_a     (req_point_a),
      .point_b     (req_point_b),
      .point_c     (req_point_c),
      .point_d     (req_point_d),
      .query_point (req_query_point),
      .out_valid   (lift_valid),
      .diff_row    (diff_row),
      .lift_sq     (lift_sq)
   );

   isd_minor #(
      .COORD_BITS (COORD_BITS)
   ) u_minor (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (lift_valid),
      .diff_row  (diff_row),
      .lift_sq   (lift_sq),
      .out_valid (minor_valid),
      .row0_diff (row0_diff),
      .row0_sq   (row0_sq),
      .minor     (minor)
   );

   isd_combine #(
      .COORD_BITS (COORD_BITS)
   ) u_combine (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (minor_valid),
      .row0_diff (row0_diff),
      .row0_sq   (row0_sq),
      .minor     (minor),
      .out_valid (rsp_valid),
      .det       (rsp_determinant)
   );

   // side code from the registered determinant
   always_comb begin
      priority if (rsp_determinant == '0) begin
         rsp_side = SIDE_ZERO;
      end else if (rsp_determinant[DET_BITS-1]) begin
         rsp_side = SIDE_NEG;
      end else begin
         rsp_side = SIDE_POS;
      end
   end

endmodule

// File: bench/tb_insphere_determinant_unit.sv
// tb_insphere_determinant_unit: self-checking bench for the in-sphere determinant unit
// depends on isd_pkg and insphere_determinant_unit; directed table then random items,
// every result compared against a hand-worked value or a built-in integer predictor

module tb_insphere_determinant_unit;
   import isd_pkg::*;

   localparam int COORD_W       = COORD_BITS_DEF;
   localparam int RANDOM_ITEMS  = 600;
   localparam int IDLE_PCT      = 14;
   localparam int HOLD_CYCLES   = 80;
   localparam int HOLD_AT_ITEM  = 420;
   localparam int SETTLE_CYCLES = 12;

   // point positions within a point set
   localparam int PT_A = 0;
   localparam int PT_B = 1;
   localparam int PT_C = 2;
   localparam int PT_D = 3;
   localparam int PT_Q = 4;

   typedef logic [4:0][POINT_BITS-1:0] point_set_type;

   typedef struct packed {
      logic signed [DET_BITS-1:0] determinant;
      side_type                   side;
   } insphere_type;

   typedef struct {
      point_set_type pts;
      bit            known;
      insphere_type  want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [POINT_BITS-1:0]  req_point_a = '0;
   logic [POINT_BITS-1:0]  req_point_b = '0;
   logic [POINT_BITS-1:0]  req_point_c = '0;
   logic [POINT_BITS-1:0]  req_point_d = '0;
   logic [POINT_BITS-1:0]  req_query_point = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic signed [DET_BITS-1:0] rsp_determinant;
   side_type               rsp_side;

   insphere_type pending_insphere [$];
   stim_row_type directed_rows [$];
   int        items_accepted = 0;
   int        results_seen = 0;
   int        results_zero = 0;
   int        results_pos = 0;
   int        results_neg = 0;
   int        errors = 0;

   insphere_determinant_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_point_a     (req_point_a),
      .req_point_b     (req_point_b),
      .req_point_c     (req_point_c),
      .req_point_d     (req_point_d),
      .req_query_point (req_query_point),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_determinant (rsp_determinant),
      .rsp_side        (rsp_side)
   );

   // clock, period 20
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   initial begin
      #4000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // one signed coordinate out of a packed point
   function automatic longint slot_coord(input logic [POINT_BITS-1:0] p, input int axis);
      logic [SLOT_BITS-1:0] raw;
      longint v;
      raw = p[axis*SLOT_BITS +: SLOT_BITS];
      v = longint'(raw) & ((longint'(1) << COORD_W) - 1);
      if (raw[COORD_W-1]) v = v - (longint'(1) << COORD_W);
      return v;
   endfunction

   function automatic longint minor3(input longint r00, r01, r02, r10, r11, r12,
                                     input longint r20, r21, r22);
      longint pos, neg;
      pos = r00 * r11 * r22 + r10 * r21 * r02 + r20 * r12 * r01;
      neg = r02 * r11 * r20 + r12 * r21 * r00 + r22 * r10 * r01;
      return pos - neg;
   endfunction

   // exact lifted determinant by cofactor expansion along the a row
   function automatic insphere_type insphere_result(input point_set_type pts);
      longint dv [4][3];
      longint sq [4];
      longint m0, m1, m2, m3, det;
      int p, k;
      insphere_type r;
      for (p = 0; p < 4; p++) begin
         sq[p] = 0;
         for (k = 0; k < AXES; k++) begin
            dv[p][k] = slot_coord(pts[p], k) - slot_coord(pts[PT_Q], k);
            sq[p] += dv[p][k] * dv[p][k];
         end
      end
      m0 = minor3(dv[1][AXIS_Y], dv[1][AXIS_Z], sq[1],
                  dv[2][AXIS_Y], dv[2][AXIS_Z], sq[2],
                  dv[3][AXIS_Y], dv[3][AXIS_Z], sq[3]);
      m1 = minor3(dv[1][AXIS_X], dv[1][AXIS_Z], sq[1],
                  dv[2][AXIS_X], dv[2][AXIS_Z], sq[2],
                  dv[3][AXIS_X], dv[3][AXIS_Z], sq[3]);
      m2 = minor3(dv[1][AXIS_X], dv[1][AXIS_Y], sq[1],
                  dv[2][AXIS_X], dv[2][AXIS_Y], sq[2],
                  dv[3][AXIS_X], dv[3][AXIS_Y], sq[3]);
      m3 = minor3(dv[1][AXIS_X], dv[1][AXIS_Y], dv[1][AXIS_Z],
                  dv[2][AXIS_X], dv[2][AXIS_Y], dv[2][AXIS_Z],
                  dv[3][AXIS_X], dv[3][AXIS_Y], dv[3][AXIS_Z]);
      det = (dv[0][AXIS_X] * m0 + dv[0][AXIS_Z] * m2)
          - (dv[0][AXIS_Y] * m1 + sq[0] * m3);
      r.determinant = det;
      r.side = (det == 0) ? SIDE_ZERO : ((det > 0) ? SIDE_POS : SIDE_NEG);
      return r;
   endfunction

   function automatic logic [POINT_BITS-1:0] pack_point(input int x, y, z);
      return {SLOT_BITS'(z), SLOT_BITS'(y), SLOT_BITS'(x)};
   endfunction

   function automatic point_set_type point_set(input logic [POINT_BITS-1:0] a, b, c, d, q);
      return {q, d, c, b, a};
   endfunction

   task automatic add_row(input point_set_type pts, input bit known,
                          input longint det_val, input side_type side_val);
      stim_row_type row;
      row.pts = pts;
      row.known = known;
      row.want.determinant = det_val;
      row.want.side = side_val;
      directed_rows.push_back(row);
   endtask

   // directed table: hand-worked values where obvious, predictor elsewhere
   task automatic build_directed_rows();
      // all zero and all minus one: every row vanishes
      add_row(point_set('0, '0, '0, '0, '0), 1'b1, 0, SIDE_ZERO);
      add_row(point_set('1, '1, '1, '1, '1), 1'b1, 0, SIDE_ZERO);
      // unit tetrahedron about the origin, and with a and b swapped
      add_row(point_set(pack_point(1, 0, 0), pack_point(0, 1, 0), pack_point(0, 0, 1),
                        pack_point(-1, 0, 0), pack_point(0, 0, 0)), 1'b1, 2, SIDE_POS);
      add_row(point_set(pack_point(0, 1, 0), pack_point(1, 0, 0), pack_point(0, 0, 1),
                        pack_point(-1, 0, 0), pack_point(0, 0, 0)), 1'b1, -2, SIDE_NEG);
      // same tetrahedron shifted, translation leaves it unchanged
      add_row(point_set(pack_point(6, -7, 3), pack_point(5, -6, 3), pack_point(5, -7, 4),
                        pack_point(4, -7, 3), pack_point(5, -7, 3)), 1'b1, 2, SIDE_POS);
      // same shape scaled to full range
      add_row(point_set(pack_point(511, 0, 0), pack_point(0, 511, 0), pack_point(0, 0, 511),
                        pack_point(-511, 0, 0), pack_point(0, 0, 0)), 1'b0, 0, SIDE_ZERO);
      // two sphere points equal
      add_row(point_set(pack_point(100, -3, 7), pack_point(100, -3, 7),
                        pack_point(-50, 20, 1), pack_point(9, 9, -9), pack_point(1, 2, 3)),
              1'b1, 0, SIDE_ZERO);
      // all five points in one plane
      add_row(point_set(pack_point(100, -200, 4), pack_point(-300, 50, 4),
                        pack_point(7, 400, 4), pack_point(-511, -512, 4), pack_point(0, 0, 4)),
              1'b1, 0, SIDE_ZERO);
      // query point on top of a sphere point
      add_row(point_set(pack_point(3, 1, 4), pack_point(-1, 5, -9), pack_point(2, -6, 5),
                        pack_point(-3, 5, 8), pack_point(-3, 5, 8)), 1'b1, 0, SIDE_ZERO);
      // query point on the sphere itself
      add_row(point_set(pack_point(1, 0, 0), pack_point(-1, 0, 0), pack_point(0, 1, 0),
                        pack_point(0, 0, 1), pack_point(0, -1, 0)), 1'b1, 0, SIDE_ZERO);
      // query point at the centre
      add_row(point_set(pack_point(1, 0, 0), pack_point(-1, 0, 0), pack_point(0, 1, 0),
                        pack_point(0, 0, 1), pack_point(0, 0, 0)), 1'b0, 0, SIDE_ZERO);
      // coordinate extremes
      add_row(point_set(pack_point(-512, -512, -512), pack_point(511, 511, 511),
                        pack_point(-512, 511, -512), pack_point(511, -512, 511),
                        pack_point(511, 511, -512)), 1'b0, 0, SIDE_ZERO);
      add_row(point_set(pack_point(511, -512, -512), pack_point(-512, 511, -512),
                        pack_point(-512, -512, 511), pack_point(511, 511, 511),
                        pack_point(-512, -512, -512)), 1'b0, 0, SIDE_ZERO);
      add_row(point_set(pack_point(-512, 511, 511), pack_point(511, -512, 511),
                        pack_point(511, 511, -512), pack_point(-512, -512, -512),
                        pack_point(511, 511, 511)), 1'b0, 0, SIDE_ZERO);
      // all sphere points at one corner, query at the other
      add_row(point_set(pack_point(-512, -512, -512), pack_point(-512, -512, -512),
                        pack_point(-512, -512, -512), pack_point(-512, -512, -512),
                        pack_point(511, 511, 511)), 1'b1, 0, SIDE_ZERO);
      // alternating bit patterns
      add_row(point_set(30'h2AAAAAAA, 30'h15555555, 30'h3FF003FF, 30'h000FFC00,
                        30'h12345678), 1'b0, 0, SIDE_ZERO);
      // small coordinates near the query point
      add_row(point_set(pack_point(2, -1, 0), pack_point(-1, 3, 1), pack_point(0, 0, -2),
                        pack_point(1, 1, 1), pack_point(0, 1, 0)), 1'b0, 0, SIDE_ZERO);
   endtask

   // random point sets: full range, corners, near the query point, degenerate
   function automatic point_set_type random_point_set();
      point_set_type pts;
      logic [SLOT_BITS-1:0] corner_vals [6];
      int pick, i, k, src, dst;
      corner_vals = '{10'h200, 10'h201, 10'h3FF, 10'h000, 10'h001, 10'h1FF};
      pick = $urandom_range(99);
      for (i = 0; i < 5; i++) pts[i] = POINT_BITS'($urandom);
      if (pick < 55) begin
      end else if (pick < 75) begin
         for (i = 0; i < 5; i++)
            for (k = 0; k < AXES; k++)
               pts[i][k*SLOT_BITS +: SLOT_BITS] = corner_vals[$urandom_range(5)];
      end else if (pick < 90) begin
         for (i = 0; i < 4; i++)
            for (k = 0; k < AXES; k++)
               pts[i][k*SLOT_BITS +: SLOT_BITS] = pts[PT_Q][k*SLOT_BITS +: SLOT_BITS]
                  + SLOT_BITS'($urandom_range(8)) - SLOT_BITS'(4);
      end else if ($urandom_range(1) == 0) begin
         src = $urandom_range(4);
         dst = (src + 1 + $urandom_range(3)) % 5;
         pts[dst] = pts[src];
      end else begin
         for (i = 0; i < 4; i++)
            pts[i][AXIS_Z*SLOT_BITS +: SLOT_BITS] = pts[PT_Q][AXIS_Z*SLOT_BITS +: SLOT_BITS];
      end
      return pts;
   endfunction

   // no idling in this window of items
   function automatic bit quiet_window();
      return items_accepted >= 150 && items_accepted < 300;
   endfunction

   // present one item, hold it until taken, then log what should come back
   task automatic offer_item(input point_set_type pts, input insphere_type want);
      while (!quiet_window() && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_point_a     <= pts[PT_A];
      req_point_b     <= pts[PT_B];
      req_point_c     <= pts[PT_C];
      req_point_d     <= pts[PT_D];
      req_query_point <= pts[PT_Q];
      do @(posedge clock); while (req_stall);
      pending_insphere.push_back(want);
      items_accepted++;
   endtask

   // result side: random stalls, one long hold to back the pipeline up
   initial begin : result_sink
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && items_accepted >= HOLD_AT_ITEM) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (quiet_window()) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // compare each taken result with the oldest outstanding expectation
   always @(posedge clock) begin : result_check
      insphere_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         unique case (rsp_side)
            SIDE_ZERO: results_zero++;
            SIDE_POS:  results_pos++;
            default:   results_neg++;
         endcase
         if (pending_insphere.size() == 0) begin
            $error("result with no item outstanding: determinant %0d", rsp_determinant);
            errors++;
         end else begin
            want = pending_insphere.pop_front();
            if (want.determinant !== rsp_determinant) begin
               $error("determinant: expected %0d, actual %0d",
                      $signed(want.determinant), rsp_determinant);
               errors++;
            end
            if (want.side !== rsp_side) begin
               $error("side: expected %0d, actual %0d", want.side, rsp_side);
               errors++;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      point_set_type pts;
      int n;
      build_directed_rows();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         offer_item(directed_rows[i].pts,
                    directed_rows[i].known ? directed_rows[i].want
                                           : insphere_result(directed_rows[i].pts));
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         pts = random_point_set();
         offer_item(pts, insphere_result(pts));
      end
      req_valid <= 1'b0;
      while (pending_insphere.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run covered %0d items (%0d from the table), one %0d-cycle output hold",
               items_accepted, directed_rows.size(), HOLD_CYCLES);
      $display("results taken %0d: %0d zero, %0d positive, %0d negative",
               results_seen, results_zero, results_pos, results_neg);
      if (errors == 0 && pending_insphere.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
